// ===== design/capture_tachometer_rpm_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Tachometer assertion macros
// Shared concurrent-assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAPTURE_TACHOMETER_RPM_FILTER_ASSERT_SVH
`define CAPTURE_TACHOMETER_RPM_FILTER_ASSERT_SVH

// same-cycle implication
`define CTRPM_A_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CTRPM_A_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ctrpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Tachometer package
// Widths, event codes, sequencer states and divider status type.
// ----------------------------------------------------------------------------
package ctrpm_pkg;

	localparam int RPM_W          = 24;
	localparam int OP_W           = 2;
	localparam int WRAP_W         = 16;
	localparam int TIMER_BITS_DEF = 16;
	localparam logic [RPM_W-1:0] TPM_RESET = 24'd15000000;

	typedef enum logic [OP_W-1:0] {
		OP_CAPTURE  = 2'd0,
		OP_OVERFLOW = 2'd1,
		OP_FILTER   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== design/ctrpm_if.sv =====
// ----------------------------------------------------------------------------
// Tachometer channel interfaces
// Valid/ready channels for events in and rpm results out.
// ----------------------------------------------------------------------------
interface ctrpm_evt_if import ctrpm_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       op;
	logic [TIMER_BITS-1:0] capture_value;

	modport source (output valid, output op, output capture_value, input ready);
	modport sink   (input valid, input op, input capture_value, output ready);
endinterface

interface ctrpm_rpm_if import ctrpm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RPM_W-1:0] raw_rpm;
	logic [RPM_W-1:0] smoothed_rpm;
	logic             bad_interval;

	modport source (output valid, output raw_rpm, output smoothed_rpm, output bad_interval,
		input ready);
	modport sink   (input valid, input raw_rpm, input smoothed_rpm, input bad_interval,
		output ready);
endinterface

// ===== design/ctrpm_div.sv =====
// ----------------------------------------------------------------------------
// Tachometer divider
// Restoring divider, one quotient bit per cycle, RPM_W-bit dividend.
// ----------------------------------------------------------------------------
module ctrpm_div import ctrpm_pkg::*; #(
	parameter int DIV_W = WRAP_W + TIMER_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RPM_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output div_stat_t        stat,
	output logic [RPM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(RPM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RPM_W-1:0] num_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	always_comb begin
		trial = {rem_q, num_q[RPM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(RPM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(RPM_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// quotient bits shift in behind the dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[RPM_W-2:0], fits};
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = num_q;

endmodule

// ===== design/capture_tachometer_rpm_filter.sv =====
// ----------------------------------------------------------------------------
// Capture tachometer rpm filter
// Fan speed from input-capture timestamps, with a half-weight smoothing filter.
// ----------------------------------------------------------------------------
// Events are taken one at a time, and the next event is not taken until the
// result of the current one has been taken. An overflow, a filter tick, an
// unused op code or the first capture gives its result in the cycle after
// acceptance. A later capture with a positive interval runs ticks_per_minute
// through the restoring divider, which produces one quotient bit per cycle;
// its result is registered once the divider has stepped through all RPM_W
// quotient bits and signalled done. A capture with a non-positive interval
// skips the divider and answers in the cycle after acceptance, bad_interval set.
module capture_tachometer_rpm_filter import ctrpm_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [RPM_W-1:0] cfg_wdata,
	ctrpm_evt_if.sink        evt,
	ctrpm_rpm_if.source      rpm
);

	`include "capture_tachometer_rpm_filter_assert.svh"

	localparam int SPAN_W = WRAP_W + TIMER_BITS;

	state_t                state_q, state_d;
	logic [RPM_W-1:0]      tpm_q;
	logic [TIMER_BITS-1:0] last_q;
	logic                  started_q;
	logic [WRAP_W-1:0]     wrap_q;
	logic [RPM_W-1:0]      raw_q;
	logic [RPM_W-1:0]      smooth_q;
	logic                  bad_q;

	logic                  acc;
	logic [WRAP_W-1:0]     extra;
	logic [SPAN_W:0]       diff;
	logic                  span_bad;
	logic                  div_start;
	logic [RPM_W:0]        avg_sum;
	div_stat_t             stat;
	logic [RPM_W-1:0]      quotient;

	assign acc = evt.valid && evt.ready;

	// interval = stamp + (wraps-1)*2^TIMER_BITS - last; borrow or zero means bad
	always_comb begin
		extra     = (wrap_q == '0) ? '0 : wrap_q - 1'b1;
		diff      = {1'b0, extra, evt.capture_value} - {{(WRAP_W + 1){1'b0}}, last_q};
		span_bad  = diff[SPAN_W] || (diff[SPAN_W-1:0] == '0);
		div_start = acc && (evt.op == OP_CAPTURE) && started_q && !span_bad;
		avg_sum   = {1'b0, raw_q} + {1'b0, smooth_q};
	end

	ctrpm_div #(.DIV_W(SPAN_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tpm_q),
		.divisor  (diff[SPAN_W-1:0]),
		.stat     (stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		evt.ready = 1'b0;
		rpm.valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				evt.ready = 1'b1;
				if (acc)
					state_d = div_start ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				if (stat.done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				rpm.valid = 1'b1;
				if (rpm.ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q     <= TPM_RESET;
			last_q    <= '0;
			started_q <= 1'b0;
			wrap_q    <= '0;
			raw_q     <= '0;
			smooth_q  <= '0;
			bad_q     <= 1'b0;
		end else begin
			if (cfg_we)
				tpm_q <= cfg_wdata;
			if (acc) begin
				bad_q <= 1'b0;
				case (evt.op)
					OP_CAPTURE: begin
						started_q <= 1'b1;
						last_q    <= evt.capture_value;
						wrap_q    <= WRAP_W'(1);
						bad_q     <= started_q && span_bad;
					end
					OP_OVERFLOW: begin
						// counts only after the first capture, saturates
						if (wrap_q != '0 && wrap_q != '1)
							wrap_q <= wrap_q + 1'b1;
					end
					OP_FILTER: smooth_q <= avg_sum[RPM_W:1];
					default: ;
				endcase
			end
			if (stat.done)
				raw_q <= quotient;
		end
	end

	assign rpm.raw_rpm      = raw_q;
	assign rpm.smoothed_rpm = smooth_q;
	assign rpm.bad_interval = bad_q;

	`CTRPM_A_IMP(a_one_side, evt.ready, !rpm.valid, "input taken while result pending")
	`CTRPM_A_IMP(a_div_state, stat.done, state_q == ST_DIV, "divider finished outside ST_DIV")
	`CTRPM_A_NXT(a_bad_hold, acc && evt.op == OP_CAPTURE && started_q && span_bad,
		$stable(raw_q) && bad_q && rpm.valid, "bad interval did not hold raw rpm")
	`CTRPM_A_IMP(a_wrap_live, started_q, wrap_q != '0, "wrap count zero after start")

endmodule

// ===== tb/sv/tach_rpm_checker.sv =====
// ----------------------------------------------------------------------------
// Tachometer rpm checker
// Watches the event, result and register ports, keeps its own copy of the
// tachometer state and checks every result transaction against a queue of
// predicted readings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tach_rpm_checker import ctrpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [RPM_W-1:0] cfg_wdata,
	ctrpm_evt_if             evt,
	ctrpm_rpm_if             rpm,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		logic [RPM_W-1:0] raw_rpm;
		logic [RPM_W-1:0] smoothed_rpm;
		logic             bad_interval;
	} rpm_reading_t;

	rpm_reading_t              readings_due[$];
	logic [RPM_W-1:0]          tpm;
	logic [TIMER_BITS_DEF-1:0] prev_stamp;
	logic                      armed;
	logic [WRAP_W-1:0]         wraps;
	logic [RPM_W-1:0]          raw_speed;
	logic [RPM_W-1:0]          smooth_speed;
	int                        mismatches = 0;

	// Advances the tachometer state by one event and returns the reading it leaves.
	function automatic rpm_reading_t tach_step(input logic [OP_W-1:0] op,
		input logic [TIMER_BITS_DEF-1:0] stamp);
		rpm_reading_t     r;
		logic [63:0]      extra;
		logic [63:0]      span;
		logic [RPM_W:0]   sum;
		r.bad_interval = 1'b0;
		case (op)
			OP_CAPTURE: begin
				if (!armed) begin
					armed = 1'b1;
				end else begin
					// wrap count n means n-1 overflows since the last capture
					extra = (wraps == '0) ? 64'd0 : 64'(wraps) - 64'd1;
					span  = 64'(stamp) + (extra << TIMER_BITS_DEF);
					if (span <= 64'(prev_stamp))
						r.bad_interval = 1'b1;
					else
						raw_speed = RPM_W'(64'(tpm) / (span - 64'(prev_stamp)));
				end
				prev_stamp = stamp;
				wraps      = WRAP_W'(1);
			end
			OP_OVERFLOW: begin
				if (wraps != '0 && wraps != '1)
					wraps = wraps + 1'b1;
			end
			OP_FILTER: begin
				sum          = {1'b0, raw_speed} + {1'b0, smooth_speed};
				smooth_speed = sum[RPM_W:1];
			end
			default: ;
		endcase
		r.raw_rpm      = raw_speed;
		r.smoothed_rpm = smooth_speed;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [RPM_W-1:0] got,
		input logic [RPM_W-1:0] want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		rpm_reading_t want;
		if (!arst_n) begin
			tpm          = TPM_RESET;
			prev_stamp   = '0;
			armed        = 1'b0;
			wraps        = '0;
			raw_speed    = '0;
			smooth_speed = '0;
			readings_due.delete();
			pending <= 0;
			errors  <= mismatches;
		end else begin
			if (cfg_we)
				tpm = cfg_wdata;
			if (evt.valid && evt.ready)
				readings_due.push_back(tach_step(evt.op, evt.capture_value));
			if (rpm.valid && rpm.ready) begin
				if (readings_due.size() == 0) begin
					report_mismatch("unexpected result, raw_rpm", rpm.raw_rpm, '0);
				end else begin
					want = readings_due.pop_front();
					if (rpm.raw_rpm !== want.raw_rpm)
						report_mismatch("raw_rpm", rpm.raw_rpm, want.raw_rpm);
					if (rpm.smoothed_rpm !== want.smoothed_rpm)
						report_mismatch("smoothed_rpm", rpm.smoothed_rpm, want.smoothed_rpm);
					if (rpm.bad_interval !== want.bad_interval)
						report_mismatch("bad_interval", RPM_W'(rpm.bad_interval),
							RPM_W'(want.bad_interval));
				end
			end
			pending <= readings_due.size();
			errors  <= mismatches;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Tachometer testbench
// Drives capture, overflow, filter and unused-code events through the
// tachometer with random idle gaps and result stalls, across several
// ticks-per-minute settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench import ctrpm_pkg::*; ();

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int PHASES          = 7;
	localparam int RANDOM_ITEMS    = 1500;
	localparam int SETTLE_CYCLES   = 32;
	localparam int HOLD_CYCLES     = 300;
	localparam int IDLE_LIMIT      = 4000;
	localparam int BURST_OVERFLOWS = 40;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [RPM_W-1:0] cfg_wdata;
	int               errors;
	int               pending;
	int               idle_cycles = 0;
	int               sent_count  = 0;
	bit               burst_mode  = 1'b0;
	bit               sender_quiet = 1'b0;
	logic [TIMER_BITS_DEF-1:0] last_cap = '0;

	ctrpm_evt_if #(.TIMER_BITS(TIMER_BITS_DEF)) evt_ch ();
	ctrpm_rpm_if rpm_ch ();

	capture_tachometer_rpm_filter #(.TIMER_BITS(TIMER_BITS_DEF)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.evt       (evt_ch),
		.rpm       (rpm_ch)
	);

	tach_rpm_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.evt       (evt_ch),
		.rpm       (rpm_ch),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// no transaction for too long: the block is stuck
	always @(posedge clk) begin
		if ((evt_ch.valid && evt_ch.ready) || (rpm_ch.valid && rpm_ch.ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("capture_tachometer_rpm_filter test failed");
			$finish;
		end
	end

	task automatic send_event(input logic [OP_W-1:0] op, input logic [TIMER_BITS_DEF-1:0] value);
		int gap;
		if (sent_count % 64 == 0)
			sender_quiet = ($urandom_range(0, 3) == 0);
		gap = (burst_mode || sender_quiet) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid         <= 1'b1;
		evt_ch.op            <= op;
		evt_ch.capture_value <= value;
		@(posedge clk);
		while (!evt_ch.ready) @(posedge clk);
		sent_count++;
	endtask

	task automatic drain_results();
		evt_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ticks_per_minute(input logic [RPM_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mostly overflow runs closed by a capture, with filter ticks; the rest is noise.
	task automatic run_speed_sequences(input int items);
		int start;
		int n_ovf;
		logic [TIMER_BITS_DEF-1:0] cap;
		start = sent_count;
		while (sent_count - start < items) begin
			if ($urandom_range(0, 99) < 75) begin
				n_ovf = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
				repeat (n_ovf) send_event(OP_OVERFLOW, 16'($urandom));
				case ($urandom_range(0, 3))
					0: cap = last_cap + 16'($urandom_range(1, 16));
					1: cap = last_cap + 16'($urandom_range(1, 20000));
					2: cap = 16'($urandom);
					default: cap = last_cap;
				endcase
				last_cap = cap;
				send_event(OP_CAPTURE, cap);
				if ($urandom_range(0, 1) == 1)
					send_event(OP_FILTER, 16'($urandom));
			end else begin
				send_event(2'($urandom_range(0, 3)), 16'($urandom));
			end
		end
	endtask

	initial begin : result_sink
		int stall;
		int taken;
		bit quiet;
		taken = 0;
		quiet = 1'b0;
		rpm_ch.ready <= 1'b0;
		forever begin
			if (taken % 64 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			stall = (burst_mode || quiet) ? 0 : $urandom_range(0, 15);
			// long hold-off so the block backs up and stalls its input
			if (taken == 200 || taken == 900)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				rpm_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rpm_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rpm_ch.valid) @(posedge clk);
			taken++;
		end
	end

	initial begin : stimulus
		logic [RPM_W-1:0] tpm_plan [PHASES];
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= '0;
		evt_ch.valid         <= 1'b0;
		evt_ch.op            <= OP_CAPTURE;
		evt_ch.capture_value <= '0;
		tpm_plan[0] = TPM_RESET;
		tpm_plan[1] = 24'd1;
		tpm_plan[2] = 24'hFFFFFF;
		tpm_plan[3] = 24'd0;
		tpm_plan[4] = 24'($urandom_range(1, 24'hFFFFFF));
		tpm_plan[5] = 24'($urandom_range(1000, 100000));
		tpm_plan[6] = 24'd60000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			write_ticks_per_minute(tpm_plan[p]);
			if (p == 0) begin
				send_event(OP_OVERFLOW, 16'h0000);   // ignored before the first capture
				send_event(OP_FILTER, 16'hFFFF);
				send_event(OP_UNUSED, 16'h0000);
				send_event(OP_CAPTURE, 16'h0000);    // first capture only stores
				send_event(OP_CAPTURE, 16'hFFFF);
				send_event(OP_CAPTURE, 16'h0000);    // negative interval
				send_event(OP_CAPTURE, 16'h0000);    // zero interval
				send_event(OP_CAPTURE, 16'h0001);    // shortest interval
				send_event(OP_FILTER, 16'h0000);
				send_event(OP_FILTER, 16'h5A5A);
				send_event(OP_OVERFLOW, 16'hFFFF);
				send_event(OP_OVERFLOW, 16'h0000);
				send_event(OP_CAPTURE, 16'h0000);    // wrapped interval
				send_event(OP_OVERFLOW, 16'h1234);
				send_event(OP_CAPTURE, 16'hFFFF);
				send_event(OP_UNUSED, 16'hFFFF);
				send_event(OP_FILTER, 16'hA5A5);
				send_event(OP_CAPTURE, 16'hFFFF);
				last_cap = 16'hFFFF;
			end
			if (p == 2) begin
				// long wrapped interval, back to back
				burst_mode = 1'b1;
				send_event(OP_CAPTURE, 16'h8000);
				repeat (BURST_OVERFLOWS) send_event(OP_OVERFLOW, 16'($urandom));
				send_event(OP_CAPTURE, 16'hFFFF);
				send_event(OP_FILTER, 16'h0000);
				last_cap = 16'hFFFF;
				burst_mode = 1'b0;
			end
			run_speed_sequences(RANDOM_ITEMS / PHASES);
		end

		drain_results();
		if (errors == 0)
			$display("capture_tachometer_rpm_filter test passed");
		else
			$display("capture_tachometer_rpm_filter test failed");
		$finish;
	end

endmodule
